// File: hw/rtl/kth_smallest_product_search_macros.svh
// Assertion macros used by the top level of the k-th smallest product search.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef KTH_SMALLEST_PRODUCT_SEARCH_MACROS_SVH
`define KTH_SMALLEST_PRODUCT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ksp_pkg.sv
// Package for the k-th smallest product search: widths, controller states,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package ksp_pkg;

	localparam int unsigned DIM_W   = 11;  // rows and cols ports
	localparam int unsigned RANK_W  = 21;  // rank port
	localparam int unsigned VALUE_W = 21;  // value port
	localparam int unsigned CAND_W  = 22;  // m*n, candidates, counts
	localparam int unsigned PROD_W  = 23;  // running product i*j during the walk
	localparam int unsigned ROW_W   = 12;  // row index, may reach m+1

	localparam int unsigned MAX_DIM_DEF = 1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIZE,
		ST_CHECK,
		ST_ROUND,
		ST_WALK,
		ST_FINISH
	} ksp_state_t;

	typedef struct packed {
		logic load;         // capture a request
		logic calc_size;    // register m*n
		logic init_search;  // range check, set lo and hi
		logic start_round;  // pick the midpoint, reset the walk
		logic walk_step;    // one step of the staircase walk
		logic update;       // narrow the search range
		logic out_load;     // write the result register
	} ksp_cmd_t;

	typedef struct packed {
		logic too_big;
		logic search_done;
		logic walk_done;
	} ksp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/ksp_dp.sv
// Datapath of the k-th smallest product search: request registers, binary
// search bounds, the division-free counting walk and the result register. Uses ksp_pkg.
`default_nettype none

module ksp_dp #(
	parameter int unsigned MAX_DIM = ksp_pkg::MAX_DIM_DEF
) (
	input  wire logic                         clk,
	input  wire ksp_pkg::ksp_cmd_t            cmd,
	output ksp_pkg::ksp_sts_t                 sts,
	input  wire logic [ksp_pkg::DIM_W-1:0]    rows,
	input  wire logic [ksp_pkg::DIM_W-1:0]    cols,
	input  wire logic [ksp_pkg::RANK_W-1:0]   rank,
	output logic      [ksp_pkg::VALUE_W-1:0]  value,
	output logic                              rank_too_big
);
	import ksp_pkg::*;

	localparam logic [DIM_W-1:0] DIM_CAP =
		(MAX_DIM >= (2 ** DIM_W - 1)) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]  m_q, n_q;
	logic [RANK_W-1:0] rank_q;
	logic [CAND_W-1:0] size_q;
	logic              too_big_q;
	logic [CAND_W-1:0] lo_q, hi_q, mid_q;
	logic [ROW_W-1:0]  i_q;
	logic [DIM_W-1:0]  j_q;
	logic [PROD_W-1:0] p_q;
	logic [CAND_W-1:0] cnt_q;

	logic [CAND_W:0]   range_sum;
	logic              too_big_d;
	logic              over;

	assign range_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign too_big_d = (size_q == '0) || ({1'b0, rank_q} > size_q);
	assign over      = p_q > {1'b0, mid_q};

	assign sts.too_big     = too_big_q;
	assign sts.search_done = lo_q >= hi_q;
	// A row with no column at or below the candidate ends the walk, as do all rows done.
	assign sts.walk_done   = (i_q > {1'b0, m_q}) || (j_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= (rows > DIM_CAP) ? DIM_CAP : rows;
			n_q    <= (cols > DIM_CAP) ? DIM_CAP : cols;
			rank_q <= rank;
		end
		if (cmd.calc_size) begin
			size_q <= CAND_W'(m_q) * CAND_W'(n_q);
		end
		if (cmd.init_search) begin
			too_big_q <= too_big_d;
			lo_q      <= CAND_W'(1);
			hi_q      <= size_q;
		end
		if (cmd.start_round) begin
			mid_q <= range_sum[CAND_W:1];
			i_q   <= ROW_W'(1);
			j_q   <= n_q;
			p_q   <= PROD_W'(n_q);
			cnt_q <= '0;
		end
		// The product i*j is kept up to date by adding a row or taking away a column.
		if (cmd.walk_step) begin
			if (over) begin
				j_q <= j_q - DIM_W'(1);
				p_q <= p_q - PROD_W'(i_q);
			end else begin
				cnt_q <= cnt_q + CAND_W'(j_q);
				i_q   <= i_q + ROW_W'(1);
				p_q   <= p_q + PROD_W'(j_q);
			end
		end
		if (cmd.update) begin
			if (cnt_q >= CAND_W'(rank_q)) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + CAND_W'(1);
			end
		end
		if (cmd.out_load) begin
			value        <= too_big_q ? '0 : lo_q[VALUE_W-1:0];
			rank_too_big <= too_big_q;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ksp_ctrl.sv
// Controller of the k-th smallest product search: sequences the search and
// owns the handshake flags. Uses ksp_pkg.
`default_nettype none

module ksp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire ksp_pkg::ksp_sts_t  sts,
	output ksp_pkg::ksp_cmd_t       cmd
);
	import ksp_pkg::*;

	ksp_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SIZE;
				end
			end
			ST_SIZE: begin
				cmd.calc_size = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.init_search = 1'b1;
				state_d         = ST_ROUND;
			end
			ST_ROUND: begin
				if (sts.too_big || sts.search_done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.start_round = 1'b1;
					state_d         = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					cmd.update = 1'b1;
					state_d    = ST_ROUND;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_FINISH: begin
				// Wait only if the previous result is still held and not taken now.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/kth_smallest_product_search.sv
// Top level of the k-th smallest product search: controller and datapath.
// Uses ksp_pkg, ksp_ctrl, ksp_dp and kth_smallest_product_search_macros.svh.
//
//   transaction   signals                       handshake
//   request       rows, cols, rank              in_valid / in_ready
//   result        value, rank_too_big           out_valid / out_ready
//
// A request runs R binary search rounds, where R is about log2(m*n), up to 20 at the
// default MAX_DIM; each round is a staircase walk of W <= m + n steps that counts the
// products at or below the candidate, one step a cycle. A request out of range goes
// from the range check straight to the finish state. Reset clears the controller only.
// A new request is taken while a finished result waits in the output register;
// the block stalls at the end of the next search until that result is taken.
`default_nettype none

`include "kth_smallest_product_search_macros.svh"

module kth_smallest_product_search #(
	parameter int unsigned MAX_DIM = ksp_pkg::MAX_DIM_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ksp_pkg::DIM_W-1:0]    rows,
	input  wire logic [ksp_pkg::DIM_W-1:0]    cols,
	input  wire logic [ksp_pkg::RANK_W-1:0]   rank,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ksp_pkg::VALUE_W-1:0]  value,
	output logic                              rank_too_big
);
	import ksp_pkg::*;

	ksp_cmd_t cmd;
	ksp_sts_t sts;

	ksp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ksp_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.rows         (rows),
		.cols         (cols),
		.rank         (rank),
		.value        (value),
		.rank_too_big (rank_too_big)
	);

	`KSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`KSP_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
	`KSP_ASSERT_SAME(a_flag_zero, out_valid && rank_too_big, value == '0, "flagged value not zero")

endmodule

`default_nettype wire

// File: verif/kth_smallest_product_search_checker.sv
// Checker for the k-th smallest product search: watches both channels, predicts each result
// from the accepted request and compares it field by field. Depends on ksp_pkg only.
`timescale 1ns / 1ps

module kth_smallest_product_search_checker #(
	parameter int unsigned MAX_DIM = ksp_pkg::MAX_DIM_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [ksp_pkg::DIM_W-1:0]    rows,
	input  wire logic [ksp_pkg::DIM_W-1:0]    cols,
	input  wire logic [ksp_pkg::RANK_W-1:0]   rank,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [ksp_pkg::VALUE_W-1:0]  value,
	input  wire logic                         rank_too_big,
	output int unsigned                       mismatch_count,
	output int unsigned                       outstanding
);

	typedef struct {
		logic [ksp_pkg::DIM_W-1:0]   rows;
		logic [ksp_pkg::DIM_W-1:0]   cols;
		logic [ksp_pkg::RANK_W-1:0]  rank;
		logic [ksp_pkg::VALUE_W-1:0] value;
		logic                        too_big;
	} product_answer_t;

	product_answer_t pending_answers[$];
	product_answer_t oldest;

	initial begin
		mismatch_count = 0;
		outstanding    = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic longint unsigned clamp_dimension(input longint unsigned d);
		return (d > MAX_DIM) ? longint'(MAX_DIM) : d;
	endfunction

	// Table entries no larger than cand: per row, the smaller of cand / row and the column count.
	function automatic longint unsigned entries_at_most(input longint unsigned cand,
			input longint unsigned m, input longint unsigned n);
		longint unsigned total;
		longint unsigned q;
		total = 0;
		for (longint unsigned r = 1; r <= m; r++) begin
			q = cand / r;
			if (q == 0)
				break;
			total += (q < n) ? q : n;
		end
		return total;
	endfunction

	function automatic product_answer_t predict_kth_product(
			input logic [ksp_pkg::DIM_W-1:0] r_in, input logic [ksp_pkg::DIM_W-1:0] c_in,
			input logic [ksp_pkg::RANK_W-1:0] k_in);
		product_answer_t ans;
		longint unsigned m, n, k, size, lo, hi, mid;
		ans.rows = r_in;
		ans.cols = c_in;
		ans.rank = k_in;
		m = clamp_dimension(r_in);
		n = clamp_dimension(c_in);
		k = k_in;
		size = m * n;
		if (size == 0 || k > size) begin
			ans.value   = '0;
			ans.too_big = 1'b1;
			return ans;
		end
		// A rank of zero ends the search at the lowest candidate, like rank one.
		lo = 1;
		hi = size;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (entries_at_most(mid, m, n) >= k)
				hi = mid;
			else
				lo = mid + 1;
		end
		ans.value   = lo[ksp_pkg::VALUE_W-1:0];
		ans.too_big = 1'b0;
		return ans;
	endfunction

	// Results are retired before the request of the same edge is queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_answers.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch($sformatf("result transaction with no request waiting: value %0d flag %0b",
						value, rank_too_big));
				end else begin
					oldest = pending_answers.pop_front();
					if (value !== oldest.value)
						report_mismatch($sformatf("rows %0d cols %0d rank %0d: value %0d, want %0d",
							oldest.rows, oldest.cols, oldest.rank, value, oldest.value));
					if (rank_too_big !== oldest.too_big)
						report_mismatch($sformatf("rows %0d cols %0d rank %0d: rank_too_big %0b, want %0b",
							oldest.rows, oldest.cols, oldest.rank, rank_too_big, oldest.too_big));
				end
			end
			if (in_valid && in_ready)
				pending_answers.push_back(predict_kth_product(rows, cols, rank));
			outstanding = pending_answers.size();
		end
	end

endmodule

// File: verif/kth_smallest_product_search_tb.sv
// Testbench top for the k-th smallest product search: clock, reset, request and result traffic.
// Depends on ksp_pkg, the block itself and kth_smallest_product_search_checker.
`timescale 1ns / 1ps

module kth_smallest_product_search_tb;

	localparam int unsigned MAX_DIM      = ksp_pkg::MAX_DIM_DEF;
	localparam int unsigned RANDOM_ITEMS = 100;
	localparam int unsigned LARGE_CAP    = 5;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 50;
	localparam longint      TIMEOUT_NS   = 60_000_000;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_ready;
	logic [ksp_pkg::DIM_W-1:0]    rows         = '0;
	logic [ksp_pkg::DIM_W-1:0]    cols         = '0;
	logic [ksp_pkg::RANK_W-1:0]   rank         = '0;
	logic                         out_valid;
	logic                         out_ready    = 1'b0;
	logic [ksp_pkg::VALUE_W-1:0]  value;
	logic                         rank_too_big;

	int unsigned mismatch_count;
	int unsigned outstanding;
	bit          send_burst = 1'b0;
	bit          take_burst = 1'b0;

	kth_smallest_product_search #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rows(rows),
		.cols(cols),
		.rank(rank),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.rank_too_big(rank_too_big)
	);

	kth_smallest_product_search_checker #(
		.MAX_DIM(MAX_DIM)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rows(rows),
		.cols(cols),
		.rank(rank),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.rank_too_big(rank_too_big),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	// Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
	task automatic send_request(input int unsigned r, input int unsigned c, input int unsigned k);
		int unsigned gap;
		if ($urandom_range(0, 11) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rows     <= r[ksp_pkg::DIM_W-1:0];
		cols     <= c[ksp_pkg::DIM_W-1:0];
		rank     <= k[ksp_pkg::RANK_W-1:0];
		do @(posedge clk); while (!in_ready);
	endtask

	// Result side: random gaps, plus two long hold-offs so the block fills and stalls its input.
	initial begin
		int unsigned gap;
		int unsigned received;
		received = 0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 11) == 0)
				take_burst = !take_burst;
			gap = take_burst ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			received++;
			if (received == 20 || received == 60) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned pick, r, c, k, m, n, size, large_sent;
		large_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tiny tables, empty tables, rank zero, ranks just past the table,
		// clamped dimensions and the full-size table.
		send_request(1, 1, 1);
		send_request(1, 1, 0);
		send_request(1, 1, 2);
		send_request(0, 5, 1);
		send_request(5, 0, 3);
		send_request(0, 0, 0);
		send_request(3, 3, 5);
		send_request(2, 3, 6);
		send_request(7, 11, 0);
		send_request(45, 37, 1000);
		send_request(1, 1024, 1024);
		send_request(1024, 1, 700);
		send_request(1024, 1024, 1);
		send_request(1024, 1024, 1048576);
		send_request(1024, 1024, 1048577);
		send_request(2047, 2047, 2097151);
		send_request(2047, 3, 3072);
		send_request(1500, 2, 2049);
		send_request(0, 2047, 2097151);
		send_request(1024, 1024, 524288);
		send_request(32, 32, 1024);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick >= 95 && large_sent >= LARGE_CAP)
				pick = 0;
			if (pick < 65) begin
				r = $urandom_range(1, 32);
				c = $urandom_range(1, 32);
				k = $urandom_range(1, r * c);
			end else if (pick < 75) begin
				r = $urandom_range(1, 96);
				c = $urandom_range(1, 96);
				k = $urandom_range(1, r * c);
			end else if (pick < 85) begin
				// Rank past the end of a table of any size: answered without a search.
				r = $urandom_range(1, 2047);
				c = $urandom_range(1, 2047);
				m = (r > MAX_DIM) ? MAX_DIM : r;
				n = (c > MAX_DIM) ? MAX_DIM : c;
				size = m * n;
				k = $urandom_range(size + 1, (1 << ksp_pkg::RANK_W) - 1);
			end else if (pick < 92) begin
				r = $urandom_range(0, 2047);
				c = $urandom_range(0, 2047);
				if ($urandom_range(0, 1) == 0)
					r = 0;
				else
					c = 0;
				k = $urandom & ((1 << ksp_pkg::RANK_W) - 1);
			end else if (pick < 95) begin
				r = $urandom_range(1, 40);
				c = $urandom_range(1, 40);
				k = ($urandom_range(0, 1) == 0) ? 0 : ($urandom & ((1 << ksp_pkg::RANK_W) - 1));
			end else begin
				r = $urandom_range(1, 2047);
				c = $urandom_range(1, 2047);
				m = (r > MAX_DIM) ? MAX_DIM : r;
				n = (c > MAX_DIM) ? MAX_DIM : c;
				k = $urandom_range(0, m * n);
				large_sent++;
			end
			send_request(r, c, k);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
